FILE: hw/rtl/ort_pkg.sv
// Shared types, widths and constants for the orbit point rotator.
// No dependencies; used by every module of the block.
`default_nettype none

package ort_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int FRACTION_BITS = 4;
   localparam int CORDIC_CELLS  = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

   localparam int COORD_W    = 24;
   localparam int ANGLE_W    = 18;
   localparam int RADIUS_W   = 20;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int MAG_W      = COORD_W;
   localparam int SQ_W       = 2 * DIFF_W;
   localparam int ROOT_W     = DIFF_W;
   localparam int REM_W      = ROOT_W + 1;
   localparam int PROD_W     = MAG_W + RADIUS_W;
   localparam int QUOT_W     = RADIUS_W + 1;
   localparam int DREM_W     = ROOT_W;
   localparam int SQRT_CELLS = ROOT_W;
   localparam int DIV_CELLS  = QUOT_W;
   localparam int WANG_W     = ANGLE_W + 1;
   localparam int RANG_W     = 16;
   localparam int GAIN_W     = 30;
   localparam int SCALED_W   = QUOT_W + 1;
   localparam int GPROD_W    = SCALED_W + GAIN_W + 1;
   localparam int GAIN_SHIFT = 14;
   localparam int GUARD_BITS = 16;
   localparam int VEC_W      = 40;
   localparam int ATAN_W     = 30;
   localparam int Z_W        = 34;
   localparam int IDX_W      = 5;
   localparam int SUM_W      = COORD_W + 2;

   localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;
   localparam logic [ROOT_W-1:0] FRAC_MASK =
      ~((ROOT_W'(1) << FRACTION_BITS) - ROOT_W'(1));

   localparam logic signed [WANG_W-1:0] DEG360 = 19'sd92160;
   localparam logic signed [WANG_W-1:0] DEG180 = 19'sd46080;
   localparam logic signed [WANG_W-1:0] DEG90  = 19'sd23040;

   localparam logic signed [SUM_W-1:0] OUT_MAX = 26'sd8388607;
   localparam logic signed [SUM_W-1:0] OUT_MIN = -26'sd8388608;

   typedef struct packed {
      logic signed [DIFF_W-1:0]  dx;
      logic signed [DIFF_W-1:0]  dy;
      logic [RADIUS_W-1:0]       rad;
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic signed [RANG_W-1:0]  ang;
      logic                      flip;
   } sq_side_type;

   typedef struct packed {
      logic [SQ_W-1:0]   n;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      sq_side_type       side;
   } sqrt_data_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic signed [RANG_W-1:0]  ang;
      logic                      flip;
      logic                      zero;
      logic                      neg_x;
      logic                      neg_y;
   } div_side_type;

   typedef struct packed {
      logic [DREM_W-1:0] rem_x;
      logic [QUOT_W-1:0] num_x;
      logic [QUOT_W-1:0] q_x;
      logic [DREM_W-1:0] rem_y;
      logic [QUOT_W-1:0] num_y;
      logic [QUOT_W-1:0] q_y;
      logic [ROOT_W-1:0] den;
      div_side_type      side;
   } div_data_type;

   typedef struct packed {
      logic signed [GPROD_W-1:0] gx;
      logic signed [GPROD_W-1:0] gy;
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic signed [RANG_W-1:0]  ang;
      logic                      flip;
      logic                      zero;
   } gain_data_type;

   typedef struct packed {
      logic signed [VEC_W-1:0]   vx;
      logic signed [VEC_W-1:0]   vy;
      logic signed [Z_W-1:0]     z;
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic                      zero;
   } cordic_data_type;

   // atan(2^-i) in 2^-24 degree
   function automatic logic [ATAN_W-1:0] atan_at(input logic [IDX_W-1:0] idx);
      logic [ATAN_W-1:0] v;
      unique case (idx)
         5'd0:  v = 30'd754974720;
         5'd1:  v = 30'd445687602;
         5'd2:  v = 30'd235489088;
         5'd3:  v = 30'd119537938;
         5'd4:  v = 30'd60000934;
         5'd5:  v = 30'd30029717;
         5'd6:  v = 30'd15018523;
         5'd7:  v = 30'd7509720;
         5'd8:  v = 30'd3754917;
         5'd9:  v = 30'd1877466;
         5'd10: v = 30'd938734;
         5'd11: v = 30'd469367;
         5'd12: v = 30'd234684;
         5'd13: v = 30'd117342;
         5'd14: v = 30'd58671;
         5'd15: v = 30'd29335;
         5'd16: v = 30'd14668;
         5'd17: v = 30'd7334;
         5'd18: v = 30'd3667;
         5'd19: v = 30'd1833;
         5'd20: v = 30'd917;
         5'd21: v = 30'd458;
         5'd22: v = 30'd229;
         5'd23: v = 30'd115;
         5'd24: v = 30'd57;
         5'd25: v = 30'd29;
         5'd26: v = 30'd14;
         5'd27: v = 30'd7;
         5'd28: v = 30'd4;
         5'd29: v = 30'd2;
         5'd30: v = 30'd1;
         5'd31: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ort_sqrt_cell.sv
// One digit cell of the integer square root chain: two radicand bits in, one root bit out.
// Depends on ort_pkg.
`default_nettype none

module ort_sqrt_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  ort_pkg::sqrt_data_type in_data,
   output logic                  out_valid,
   output ort_pkg::sqrt_data_type out_data
);

   logic [ort_pkg::REM_W+1:0] rem_sh;
   logic [ort_pkg::REM_W+1:0] trial;
   logic [ort_pkg::REM_W+1:0] diff;
   logic                      ge;
   logic                      valid_ff;
   logic                      valid_in;
   ort_pkg::sqrt_data_type    data_ff;
   ort_pkg::sqrt_data_type    data_in;

   always_comb begin
      rem_sh = {in_data.rem, in_data.n[ort_pkg::SQ_W-1 -: 2]};
      trial  = {1'b0, in_data.root, 2'b01};
      diff   = rem_sh - trial;
      ge     = (rem_sh >= trial);
      data_in.n    = {in_data.n[ort_pkg::SQ_W-3:0], 2'b00};
      data_in.rem  = ge ? diff[ort_pkg::REM_W-1:0] : rem_sh[ort_pkg::REM_W-1:0];
      data_in.root = {in_data.root[ort_pkg::ROOT_W-2:0], ge};
      data_in.side = in_data.side;
      valid_in     = advance ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/ort_div_cell.sv
// One quotient-bit cell of the restoring divider chain, x and y lanes side by side.
// Depends on ort_pkg.
`default_nettype none

module ort_div_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  ort_pkg::div_data_type in_data,
   output logic                 out_valid,
   output ort_pkg::div_data_type out_data
);

   logic [ort_pkg::DREM_W:0] sh_x;
   logic [ort_pkg::DREM_W:0] sh_y;
   logic [ort_pkg::DREM_W:0] dv;
   logic [ort_pkg::DREM_W:0] diff_x;
   logic [ort_pkg::DREM_W:0] diff_y;
   logic                     ge_x;
   logic                     ge_y;
   logic                     valid_ff;
   logic                     valid_in;
   ort_pkg::div_data_type    data_ff;
   ort_pkg::div_data_type    data_in;

   always_comb begin
      dv     = {1'b0, in_data.den};
      sh_x   = {in_data.rem_x, in_data.num_x[ort_pkg::QUOT_W-1]};
      sh_y   = {in_data.rem_y, in_data.num_y[ort_pkg::QUOT_W-1]};
      diff_x = sh_x - dv;
      diff_y = sh_y - dv;
      ge_x   = (sh_x >= dv);
      ge_y   = (sh_y >= dv);
      data_in.rem_x = ge_x ? diff_x[ort_pkg::DREM_W-1:0] : sh_x[ort_pkg::DREM_W-1:0];
      data_in.rem_y = ge_y ? diff_y[ort_pkg::DREM_W-1:0] : sh_y[ort_pkg::DREM_W-1:0];
      data_in.num_x = {in_data.num_x[ort_pkg::QUOT_W-2:0], 1'b0};
      data_in.num_y = {in_data.num_y[ort_pkg::QUOT_W-2:0], 1'b0};
      data_in.q_x   = {in_data.q_x[ort_pkg::QUOT_W-2:0], ge_x};
      data_in.q_y   = {in_data.q_y[ort_pkg::QUOT_W-2:0], ge_y};
      data_in.den   = in_data.den;
      data_in.side  = in_data.side;
      valid_in      = advance ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/ort_cordic_cell.sv
// One micro-rotation cell of the CORDIC chain; stage index selects shift and atan step.
// Depends on ort_pkg.
`default_nettype none

module ort_cordic_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic [ort_pkg::IDX_W-1:0]    stage_idx,
   input  logic                         in_valid,
   input  ort_pkg::cordic_data_type     in_data,
   output logic                         out_valid,
   output ort_pkg::cordic_data_type     out_data
);

   logic signed [ort_pkg::VEC_W-1:0] xs;
   logic signed [ort_pkg::VEC_W-1:0] ys;
   logic signed [ort_pkg::Z_W-1:0]   step;
   logic                             valid_ff;
   logic                             valid_in;
   ort_pkg::cordic_data_type         data_ff;
   ort_pkg::cordic_data_type         data_in;

   always_comb begin
      xs   = in_data.vx >>> stage_idx;
      ys   = in_data.vy >>> stage_idx;
      step = $signed({{(ort_pkg::Z_W-ort_pkg::ATAN_W){1'b0}}, ort_pkg::atan_at(stage_idx)});
      data_in = in_data;
      if (!in_data.z[ort_pkg::Z_W-1]) begin
         data_in.vx = in_data.vx - ys;
         data_in.vy = in_data.vy + xs;
         data_in.z  = in_data.z - step;
      end else begin
         data_in.vx = in_data.vx + ys;
         data_in.vy = in_data.vy - xs;
         data_in.z  = in_data.z + step;
      end
      valid_in = advance ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/orbit_point_rotate.sv
// Top level of the orbit point rotator: front end, root, divider and CORDIC chains, output.
// Depends on ort_pkg, ort_sqrt_cell, ort_div_cell, ort_cordic_cell.
//
//   channel | ports          | direction | handshake
//   --------+----------------+-----------+-------------------
//   request | req_*          | in        | req_valid / req_ready
//   result  | rsp_*          | out       | rsp_valid / rsp_ready
//
// One transfer in per cycle unless rsp_ready back-pressure has filled every stage; one
// result per item, through stages A to G and the root, divider and CORDIC cell chains.
// Every stage holds a valid bit and moves on when it or a later stage has room,
// so bubbles close up and the front keeps taking transfers while a result waits.
// Reset clears the valid bits only.
`default_nettype none

module orbit_point_rotate (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [23:0] req_point_x,
   input  logic [23:0] req_point_y,
   input  logic [23:0] req_pivot_x,
   input  logic [23:0] req_pivot_y,
   input  logic [17:0] req_turn_angle,
   input  logic [19:0] req_orbit_radius,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [23:0] rsp_result_x,
   output logic [23:0] rsp_result_y,
   output logic        rsp_zero_distance
);

   localparam int IDX_A   = 0;
   localparam int IDX_B   = 1;
   localparam int IDX_C   = 2;
   localparam int IDX_SQ0 = 3;
   localparam int IDX_D   = IDX_SQ0 + ort_pkg::SQRT_CELLS;
   localparam int IDX_DV0 = IDX_D + 1;
   localparam int IDX_E   = IDX_DV0 + ort_pkg::DIV_CELLS;
   localparam int IDX_F   = IDX_E + 1;
   localparam int IDX_CR0 = IDX_F + 1;
   localparam int IDX_G   = IDX_CR0 + ort_pkg::CORDIC_CELLS;
   localparam int N_STAGES = IDX_G + 1;
   localparam int HIGH_W  = ort_pkg::PROD_W - ort_pkg::QUOT_W;

   logic [N_STAGES-1:0] stage_valid;
   logic [N_STAGES-1:0] advance;

   // stage A: offsets and angle reduction
   logic signed [ort_pkg::WANG_W-1:0] ang0;
   logic signed [ort_pkg::WANG_W-1:0] ang1;
   logic signed [ort_pkg::WANG_W-1:0] ang2;
   logic signed [ort_pkg::WANG_W-1:0] ang3;
   logic                              flip;
   ort_pkg::sq_side_type              a_in;
   ort_pkg::sq_side_type              a_ff;
   logic                              a_valid_ff;
   logic                              a_valid_in;

   // stage B: squares
   logic [ort_pkg::SQ_W-1:0]          sqx_in;
   logic [ort_pkg::SQ_W-1:0]          sqy_in;
   logic [ort_pkg::SQ_W-1:0]          sqx_ff;
   logic [ort_pkg::SQ_W-1:0]          sqy_ff;
   ort_pkg::sq_side_type              b_ff;
   logic                              b_valid_ff;
   logic                              b_valid_in;

   // stage C: sum of squares
   ort_pkg::sqrt_data_type            c_in;
   ort_pkg::sqrt_data_type            c_ff;
   logic                              c_valid_ff;
   logic                              c_valid_in;

   ort_pkg::sqrt_data_type            sq_link [ort_pkg::SQRT_CELLS+1];

   // stage D: denominator and numerators
   ort_pkg::sqrt_data_type            sq_last;
   logic [ort_pkg::MAG_W-1:0]         mag_x;
   logic [ort_pkg::MAG_W-1:0]         mag_y;
   logic [ort_pkg::PROD_W-1:0]        prod_x;
   logic [ort_pkg::PROD_W-1:0]        prod_y;
   logic [ort_pkg::ROOT_W-1:0]        den;
   ort_pkg::div_data_type             d_in;
   ort_pkg::div_data_type             d_ff;
   logic                              d_valid_ff;
   logic                              d_valid_in;

   ort_pkg::div_data_type             dv_link [ort_pkg::DIV_CELLS+1];

   // stage E: signed quotient times gain
   ort_pkg::div_data_type             dv_last;
   logic signed [ort_pkg::SCALED_W-1:0] sx;
   logic signed [ort_pkg::SCALED_W-1:0] sy;
   ort_pkg::gain_data_type            e_in;
   ort_pkg::gain_data_type            e_ff;
   logic                              e_valid_ff;
   logic                              e_valid_in;

   // stage F: guard alignment, half-turn flip, angle scaling
   logic signed [ort_pkg::GPROD_W-1:0] gsx;
   logic signed [ort_pkg::GPROD_W-1:0] gsy;
   logic signed [ort_pkg::VEC_W-1:0]   vx0;
   logic signed [ort_pkg::VEC_W-1:0]   vy0;
   ort_pkg::cordic_data_type          f_in;
   ort_pkg::cordic_data_type          f_ff;
   logic                              f_valid_ff;
   logic                              f_valid_in;

   ort_pkg::cordic_data_type          cr_link [ort_pkg::CORDIC_CELLS+1];

   // stage G: rounding, pivot add, saturation, pivot output on zero distance
   ort_pkg::cordic_data_type          cr_last;
   logic signed [ort_pkg::VEC_W:0]    rnd_x;
   logic signed [ort_pkg::VEC_W:0]    rnd_y;
   logic signed [ort_pkg::VEC_W:0]    shx;
   logic signed [ort_pkg::VEC_W:0]    shy;
   logic signed [ort_pkg::SUM_W-1:0]  sum_x;
   logic signed [ort_pkg::SUM_W-1:0]  sum_y;
   logic [ort_pkg::COORD_W-1:0]       res_x_in;
   logic [ort_pkg::COORD_W-1:0]       res_y_in;
   logic [ort_pkg::COORD_W-1:0]       res_x_ff;
   logic [ort_pkg::COORD_W-1:0]       res_y_ff;
   logic                              zero_ff;
   logic                              g_valid_ff;
   logic                              g_valid_in;

   // flow control: a stage moves when it is empty or the next one moves
   assign advance[N_STAGES-1] = !stage_valid[N_STAGES-1] || rsp_ready;
   for (genvar k = 0; k < N_STAGES - 1; k++) begin : g_adv
      assign advance[k] = !stage_valid[k] || advance[k+1];
   end

   assign stage_valid[IDX_A] = a_valid_ff;
   assign stage_valid[IDX_B] = b_valid_ff;
   assign stage_valid[IDX_C] = c_valid_ff;
   assign stage_valid[IDX_D] = d_valid_ff;
   assign stage_valid[IDX_E] = e_valid_ff;
   assign stage_valid[IDX_F] = f_valid_ff;
   assign stage_valid[IDX_G] = g_valid_ff;

   assign req_ready = advance[IDX_A];

   // stage A
   always_comb begin
      ang0 = $signed({req_turn_angle[ort_pkg::ANGLE_W-1], req_turn_angle});
      priority if (ang0 >= ort_pkg::DEG360) begin
         ang1 = ang0 - ort_pkg::DEG360;
      end else if (ang0 <= -ort_pkg::DEG360) begin
         ang1 = ang0 + ort_pkg::DEG360;
      end else begin
         ang1 = ang0;
      end
      priority if (ang1 >= ort_pkg::DEG180) begin
         ang2 = ang1 - ort_pkg::DEG360;
      end else if (ang1 < -ort_pkg::DEG180) begin
         ang2 = ang1 + ort_pkg::DEG360;
      end else begin
         ang2 = ang1;
      end
      priority if (ang2 > ort_pkg::DEG90) begin
         ang3 = ang2 - ort_pkg::DEG180;
         flip = 1'b1;
      end else if (ang2 < -ort_pkg::DEG90) begin
         ang3 = ang2 + ort_pkg::DEG180;
         flip = 1'b1;
      end else begin
         ang3 = ang2;
         flip = 1'b0;
      end
      a_in.dx   = $signed({req_point_x[23], req_point_x}) - $signed({req_pivot_x[23], req_pivot_x});
      a_in.dy   = $signed({req_point_y[23], req_point_y}) - $signed({req_pivot_y[23], req_pivot_y});
      a_in.rad  = req_orbit_radius;
      a_in.cx   = $signed(req_pivot_x);
      a_in.cy   = $signed(req_pivot_y);
      a_in.ang  = ang3[ort_pkg::RANG_W-1:0];
      a_in.flip = flip;
      a_valid_in = advance[IDX_A] ? req_valid : a_valid_ff;
   end

   // stage B
   always_comb begin
      sqx_in = a_ff.dx * a_ff.dx;
      sqy_in = a_ff.dy * a_ff.dy;
      b_valid_in = advance[IDX_B] ? a_valid_ff : b_valid_ff;
   end

   // stage C
   always_comb begin
      c_in.n    = sqx_ff + sqy_ff;
      c_in.rem  = '0;
      c_in.root = '0;
      c_in.side = b_ff;
      c_valid_in = advance[IDX_C] ? b_valid_ff : c_valid_ff;
   end

   assign sq_link[0] = c_ff;

   for (genvar k = 0; k < ort_pkg::SQRT_CELLS; k++) begin : g_sqrt
      ort_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance[IDX_SQ0+k]),
         .in_valid  (stage_valid[IDX_SQ0+k-1]),
         .in_data   (sq_link[k]),
         .out_valid (stage_valid[IDX_SQ0+k]),
         .out_data  (sq_link[k+1])
      );
   end

   // stage D
   always_comb begin
      sq_last = sq_link[ort_pkg::SQRT_CELLS];
      mag_x   = sq_last.side.dx[ort_pkg::DIFF_W-1] ?
                ort_pkg::MAG_W'(-sq_last.side.dx) : ort_pkg::MAG_W'(sq_last.side.dx);
      mag_y   = sq_last.side.dy[ort_pkg::DIFF_W-1] ?
                ort_pkg::MAG_W'(-sq_last.side.dy) : ort_pkg::MAG_W'(sq_last.side.dy);
      prod_x  = mag_x * sq_last.side.rad;
      prod_y  = mag_y * sq_last.side.rad;
      den     = sq_last.root & ort_pkg::FRAC_MASK;
      d_in.rem_x = ort_pkg::DREM_W'(prod_x[ort_pkg::PROD_W-1 -: HIGH_W]);
      d_in.rem_y = ort_pkg::DREM_W'(prod_y[ort_pkg::PROD_W-1 -: HIGH_W]);
      d_in.num_x = prod_x[ort_pkg::QUOT_W-1:0];
      d_in.num_y = prod_y[ort_pkg::QUOT_W-1:0];
      d_in.q_x   = '0;
      d_in.q_y   = '0;
      d_in.den   = den;
      d_in.side.cx    = sq_last.side.cx;
      d_in.side.cy    = sq_last.side.cy;
      d_in.side.ang   = sq_last.side.ang;
      d_in.side.flip  = sq_last.side.flip;
      d_in.side.zero  = (den == '0);
      d_in.side.neg_x = sq_last.side.dx[ort_pkg::DIFF_W-1];
      d_in.side.neg_y = sq_last.side.dy[ort_pkg::DIFF_W-1];
      d_valid_in = advance[IDX_D] ? stage_valid[IDX_D-1] : d_valid_ff;
   end

   assign dv_link[0] = d_ff;

   for (genvar k = 0; k < ort_pkg::DIV_CELLS; k++) begin : g_div
      ort_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance[IDX_DV0+k]),
         .in_valid  (stage_valid[IDX_DV0+k-1]),
         .in_data   (dv_link[k]),
         .out_valid (stage_valid[IDX_DV0+k]),
         .out_data  (dv_link[k+1])
      );
   end

   // stage E
   always_comb begin
      dv_last = dv_link[ort_pkg::DIV_CELLS];
      sx = dv_last.side.neg_x ? -$signed({1'b0, dv_last.q_x}) : $signed({1'b0, dv_last.q_x});
      sy = dv_last.side.neg_y ? -$signed({1'b0, dv_last.q_y}) : $signed({1'b0, dv_last.q_y});
      e_in.gx   = sx * $signed({1'b0, ort_pkg::GAIN_Q30});
      e_in.gy   = sy * $signed({1'b0, ort_pkg::GAIN_Q30});
      e_in.cx   = dv_last.side.cx;
      e_in.cy   = dv_last.side.cy;
      e_in.ang  = dv_last.side.ang;
      e_in.flip = dv_last.side.flip;
      e_in.zero = dv_last.side.zero;
      e_valid_in = advance[IDX_E] ? stage_valid[IDX_E-1] : e_valid_ff;
   end

   // stage F
   always_comb begin
      gsx = e_ff.gx >>> ort_pkg::GAIN_SHIFT;
      gsy = e_ff.gy >>> ort_pkg::GAIN_SHIFT;
      vx0 = $signed(gsx[ort_pkg::VEC_W-1:0]);
      vy0 = $signed(gsy[ort_pkg::VEC_W-1:0]);
      f_in.vx   = e_ff.flip ? -vx0 : vx0;
      f_in.vy   = e_ff.flip ? -vy0 : vy0;
      f_in.z    = $signed({{(ort_pkg::Z_W-ort_pkg::RANG_W-16){e_ff.ang[ort_pkg::RANG_W-1]}},
                           e_ff.ang, 16'b0});
      f_in.cx   = e_ff.cx;
      f_in.cy   = e_ff.cy;
      f_in.zero = e_ff.zero;
      f_valid_in = advance[IDX_F] ? e_valid_ff : f_valid_ff;
   end

   assign cr_link[0] = f_ff;

   for (genvar k = 0; k < ort_pkg::CORDIC_CELLS; k++) begin : g_cordic
      ort_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance[IDX_CR0+k]),
         .stage_idx (ort_pkg::IDX_W'(k)),
         .in_valid  (stage_valid[IDX_CR0+k-1]),
         .in_data   (cr_link[k]),
         .out_valid (stage_valid[IDX_CR0+k]),
         .out_data  (cr_link[k+1])
      );
   end

   // stage G
   always_comb begin
      cr_last = cr_link[ort_pkg::CORDIC_CELLS];
      rnd_x = $signed({cr_last.vx[ort_pkg::VEC_W-1], cr_last.vx})
              + $signed((ort_pkg::VEC_W+1)'(1) << (ort_pkg::GUARD_BITS - 1));
      rnd_y = $signed({cr_last.vy[ort_pkg::VEC_W-1], cr_last.vy})
              + $signed((ort_pkg::VEC_W+1)'(1) << (ort_pkg::GUARD_BITS - 1));
      shx   = rnd_x >>> ort_pkg::GUARD_BITS;
      shy   = rnd_y >>> ort_pkg::GUARD_BITS;
      sum_x = $signed(shx[ort_pkg::SUM_W-1:0])
              + $signed({{(ort_pkg::SUM_W-ort_pkg::COORD_W){cr_last.cx[ort_pkg::COORD_W-1]}},
                         cr_last.cx});
      sum_y = $signed(shy[ort_pkg::SUM_W-1:0])
              + $signed({{(ort_pkg::SUM_W-ort_pkg::COORD_W){cr_last.cy[ort_pkg::COORD_W-1]}},
                         cr_last.cy});
      priority if (cr_last.zero) begin
         res_x_in = cr_last.cx;
      end else if (sum_x > ort_pkg::OUT_MAX) begin
         res_x_in = ort_pkg::OUT_MAX[ort_pkg::COORD_W-1:0];
      end else if (sum_x < ort_pkg::OUT_MIN) begin
         res_x_in = ort_pkg::OUT_MIN[ort_pkg::COORD_W-1:0];
      end else begin
         res_x_in = sum_x[ort_pkg::COORD_W-1:0];
      end
      priority if (cr_last.zero) begin
         res_y_in = cr_last.cy;
      end else if (sum_y > ort_pkg::OUT_MAX) begin
         res_y_in = ort_pkg::OUT_MAX[ort_pkg::COORD_W-1:0];
      end else if (sum_y < ort_pkg::OUT_MIN) begin
         res_y_in = ort_pkg::OUT_MIN[ort_pkg::COORD_W-1:0];
      end else begin
         res_y_in = sum_y[ort_pkg::COORD_W-1:0];
      end
      g_valid_in = advance[IDX_G] ? stage_valid[IDX_G-1] : g_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
         d_valid_ff <= d_valid_in;
         e_valid_ff <= e_valid_in;
         f_valid_ff <= f_valid_in;
         g_valid_ff <= g_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance[IDX_A]) begin
         a_ff <= a_in;
      end
      if (advance[IDX_B]) begin
         sqx_ff <= sqx_in;
         sqy_ff <= sqy_in;
         b_ff   <= a_ff;
      end
      if (advance[IDX_C]) begin
         c_ff <= c_in;
      end
      if (advance[IDX_D]) begin
         d_ff <= d_in;
      end
      if (advance[IDX_E]) begin
         e_ff <= e_in;
      end
      if (advance[IDX_F]) begin
         f_ff <= f_in;
      end
      if (advance[IDX_G]) begin
         res_x_ff <= res_x_in;
         res_y_ff <= res_y_in;
         zero_ff  <= cr_last.zero;
      end
   end

   assign rsp_valid         = g_valid_ff;
   assign rsp_result_x      = res_x_ff;
   assign rsp_result_y      = res_y_ff;
   assign rsp_zero_distance = zero_ff;

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking bench for orbit_point_rotate: directed table, then random items.
// Untyped items are predicted by a local fixed-point model. Depends on ort_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;

   typedef struct {
      logic signed [23:0] px, py, cx, cy;
      logic signed [17:0] ang;
      logic [19:0]        rad;
   } rot_req_type;

   typedef struct {
      logic [23:0] x, y;
      logic        zero;
   } rot_rsp_type;

   typedef struct {
      rot_req_type req;
      bit          typed;
      rot_rsp_type rsp;
   } row_type;

   logic        clock, reset;
   logic        req_valid, req_ready, rsp_valid, rsp_ready, rsp_zero_distance;
   logic [23:0] req_point_x, req_point_y, req_pivot_x, req_pivot_y;
   logic [17:0] req_turn_angle;
   logic [19:0] req_orbit_radius;
   logic [23:0] rsp_result_x, rsp_result_y;

   rot_rsp_type rotated_q[$];
   int          errors, idle_pct, stall_pct, quiet;

   orbit_point_rotate u_dut (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   function automatic longint unsigned int_root(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint clamp24(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   function automatic rot_rsp_type rotate_point(rot_req_type r);
      rot_rsp_type o;
      longint dx, dy, span, sx, sy, vx, vy, z, a, xs, ys, at;
      dx = longint'(r.px) - longint'(r.cx);
      dy = longint'(r.py) - longint'(r.cy);
      span = longint'(int_root(dx * dx + dy * dy) >> ort_pkg::FRACTION_BITS);
      if (span == 0) begin
         o.x = r.cx;
         o.y = r.cy;
         o.zero = 1'b1;
         return o;
      end
      sx = (dx * longint'(r.rad)) / (span << ort_pkg::FRACTION_BITS);
      sy = (dy * longint'(r.rad)) / (span << ort_pkg::FRACTION_BITS);
      vx = (sx * longint'(ort_pkg::GAIN_Q30)) >>> ort_pkg::GAIN_SHIFT;
      vy = (sy * longint'(ort_pkg::GAIN_Q30)) >>> ort_pkg::GAIN_SHIFT;
      a = longint'(r.ang) % longint'(ort_pkg::DEG360);
      if (a >= ort_pkg::DEG180) a -= ort_pkg::DEG360;
      if (a < -longint'(ort_pkg::DEG180)) a += ort_pkg::DEG360;
      if (a > ort_pkg::DEG90) begin
         vx = -vx; vy = -vy; a -= ort_pkg::DEG180;
      end else if (a < -longint'(ort_pkg::DEG90)) begin
         vx = -vx; vy = -vy; a += ort_pkg::DEG180;
      end
      z = a * 65536;
      for (int i = 0; i < ort_pkg::CORDIC_CELLS; i++) begin
         xs = vx >>> i;
         ys = vy >>> i;
         at = longint'(ort_pkg::atan_at(ort_pkg::IDX_W'(i)));
         if (z >= 0) begin
            vx -= ys; vy += xs; z -= at;
         end else begin
            vx += ys; vy -= xs; z += at;
         end
      end
      o.x = 24'(clamp24(((vx + (64'sd1 <<< (ort_pkg::GUARD_BITS - 1)))
                         >>> ort_pkg::GUARD_BITS) + r.cx));
      o.y = 24'(clamp24(((vy + (64'sd1 <<< (ort_pkg::GUARD_BITS - 1)))
                         >>> ort_pkg::GUARD_BITS) + r.cy));
      o.zero = 1'b0;
      return o;
   endfunction

   task automatic report(string what, logic [23:0] got, logic [23:0] want);
      errors++;
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
   endtask

   // Result side: random stall and compare.
   always @(posedge clock) begin
      rot_rsp_type e;
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rotated_q.size() == 0) begin
               report("unexpected transfer", rsp_result_x, 24'd0);
            end else begin
               e = rotated_q.pop_front();
               if (rsp_result_x !== e.x) report("result_x", rsp_result_x, e.x);
               if (rsp_result_y !== e.y) report("result_y", rsp_result_y, e.y);
               if (rsp_zero_distance !== e.zero)
                  report("zero_distance", 24'(rsp_zero_distance), 24'(e.zero));
            end
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet <= 0;
      end else if (quiet > 5000) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   task automatic send(rot_req_type r, bit typed, rot_rsp_type want);
      rot_rsp_type p;
      req_valid        <= 1;
      req_point_x      <= r.px;
      req_point_y      <= r.py;
      req_pivot_x      <= r.cx;
      req_pivot_y      <= r.cy;
      req_turn_angle   <= r.ang;
      req_orbit_radius <= r.rad;
      do @(posedge clock); while (!(req_valid && req_ready));
      p = typed ? want : rotate_point(r);
      rotated_q.push_back(p);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   function automatic rot_req_type mk(int px, int py, int cx, int cy, int ang, int rad);
      rot_req_type r;
      r.px = 24'(px); r.py = 24'(py); r.cx = 24'(cx); r.cy = 24'(cy);
      r.ang = 18'(ang); r.rad = 20'(rad);
      return r;
   endfunction

   function automatic rot_req_type random_req();
      rot_req_type r;
      int sc;
      r.cx = 24'($urandom);
      r.cy = 24'($urandom);
      sc = $urandom_range(24, 0);
      case ($urandom_range(3))
         0: begin
            r.px = 24'($urandom);
            r.py = 24'($urandom);
         end
         default: begin
            r.px = 24'(r.cx + (int'($urandom) >>> (31 - sc)));
            r.py = 24'(r.cy + (int'($urandom) >>> (31 - sc)));
         end
      endcase
      r.ang = ($urandom_range(3) == 0) ? 18'($urandom)
                                       : 18'($urandom_range(184320) - 92160);
      r.rad = 20'($urandom) >> $urandom_range(19, 0);
      return r;
   endfunction

   row_type     table_rows[$];
   rot_rsp_type none;

   initial begin
      row_type rw;
      errors = 0;
      idle_pct = 0;
      stall_pct = 0;
      none = '{0, 0, 0};
      reset = 1;
      req_valid = 0;
      req_point_x = 0; req_point_y = 0; req_pivot_x = 0; req_pivot_y = 0;
      req_turn_angle = 0; req_orbit_radius = 0;
      repeat (7) @(posedge clock);
      reset <= 0;

      // zero distance (offset under 16 units) and zero radius have known answers
      table_rows.push_back('{mk(100, 200, 100, 200, 1000, 5000), 1, '{100, 200, 1}});
      table_rows.push_back('{mk(11, -11, 0, 0, 0, 1048575), 1, '{0, 0, 1}});
      table_rows.push_back('{mk(-8388608, 8388607, -8388608, 8388607, -131072, 0), 1,
                             '{24'h800000, 24'h7fffff, 1}});
      table_rows.push_back('{mk(5000, 0, 0, 0, 12345, 0), 1, '{0, 0, 0}});
      table_rows.push_back('{mk(8388607, 8388607, -8388608, -8388608, 0, 1048575), 0, none});
      table_rows.push_back('{mk(-8388608, -8388608, 8388607, 8388607, 131071, 1048575), 0,
                             none});
      table_rows.push_back('{mk(16, 0, 0, 0, 0, 1048575), 0, none});
      table_rows.push_back('{mk(1600, 0, 8388000, 0, 0, 1048575), 0, none});
      table_rows.push_back('{mk(1600, 0, -8388000, 0, 46080, 1048575), 0, none});
      table_rows.push_back('{mk(0, 1600, 0, -8388000, -23040, 1048575), 0, none});
      for (int a = -131072; a <= 131071; a += 23040) begin
         table_rows.push_back('{mk(1600, 800, 0, 0, a, 4096), 0, none});
      end
      table_rows.push_back('{mk(1600, 800, 0, 0, 23040, 4096), 0, none});
      table_rows.push_back('{mk(1600, 800, 0, 0, -23040, 4096), 0, none});
      table_rows.push_back('{mk(1600, 800, 0, 0, 46080, 4096), 0, none});
      table_rows.push_back('{mk(1600, 800, 0, 0, -46080, 4096), 0, none});
      table_rows.push_back('{mk(1600, 800, 0, 0, 131071, 4096), 0, none});
      foreach (table_rows[k]) begin
         rw = table_rows[k];
         send(rw.req, rw.typed, rw.rsp);
      end

      // drain fully before the random part
      req_valid <= 0;
      while (rotated_q.size() != 0) @(posedge clock);

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 79; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 79; end
            3: begin idle_pct = 26; stall_pct = 26; end
            default: begin idle_pct = 0; stall_pct = 0; end
         endcase
         for (int n = 0; n < 400; n++) send(random_req(), 0, none);
      end
      req_valid <= 0;

      while (rotated_q.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire

FILE: filelist.f
hw/rtl/ort_pkg.sv
hw/rtl/ort_sqrt_cell.sv
hw/rtl/ort_div_cell.sv
hw/rtl/ort_cordic_cell.sv
hw/rtl/orbit_point_rotate.sv
bench/tb_top.sv
